/* rtl/lfo_waveform_generator_macros.svh */
// assertion macros for the lfo block, clocked on clk and disabled in reset
`ifndef LFO_WAVEFORM_GENERATOR_MACROS_SVH
`define LFO_WAVEFORM_GENERATOR_MACROS_SVH

`ifndef SYNTHESIS
`define LFO_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lfo assertion failed");
`define LFO_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lfo assertion failed");
`else
`define LFO_ASSERT_SAME(lbl, ante, cons)
`define LFO_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* rtl/lfo_pkg.sv */
package lfo_pkg;

	// wave mode codes
	localparam logic [2:0] WAVE_SINE     = 3'd0;
	localparam logic [2:0] WAVE_SQUARE   = 3'd1;
	localparam logic [2:0] WAVE_TRIANGLE = 3'd2;
	localparam logic [2:0] WAVE_SAW      = 3'd3;
	localparam logic [2:0] WAVE_NOISE    = 3'd4;

	// configuration register indexes
	localparam logic [2:0] REG_WAVE_MODE    = 3'd0;
	localparam logic [2:0] REG_RANGE_LOW    = 3'd1;
	localparam logic [2:0] REG_RANGE_HIGH   = 3'd2;
	localparam logic [2:0] REG_CYCLE_RATE   = 3'd3;
	localparam logic [2:0] REG_PHASE_OFFSET = 3'd4;

	// reset values
	localparam logic [15:0] RANGE_HIGH_RST = 16'h7FFF;
	localparam logic [31:0] CYCLE_RATE_RST = 32'h0000_1000;
	localparam logic [31:0] LFSR_SEED      = 32'h0000_0001;

	// galois feedback mask for x^32+x^22+x^2+x+1
	localparam logic [31:0] LFSR_MASK = 32'h8020_0003;

	// offset wave value (w + 1.0), full scale is 2.0
	localparam logic [16:0] U_MID  = 17'h0_8000;
	localparam logic [16:0] U_FULL = 17'h1_0000;
	localparam logic [16:0] U_ZERO = 17'h0_0000;

	// quarter-wave sine polynomial, evaluated at elaboration for the table
	function automatic logic [15:0] quarter_sine(input int unsigned k, input int unsigned bits);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		x  = 64'(k) << (16 - bits);
		x2 = (x * x) >> 16;
		t  = (64'd4926 * x2) >> 16;
		t  = 64'd42334 - t;
		t  = (t * x2) >> 16;
		t  = 64'd102944 - t;
		t  = (t * x) >> 16;
		t  = (t + 64'd1) >> 1;
		if (t > 64'd32768) begin
			t = 64'd32768;
		end
		return t[15:0];
	endfunction

endpackage

/* rtl/lfo_if.sv */
// tick channel: one item per frame
interface lfo_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] delta_time;
	modport source (output valid, output delta_time, input ready);
	modport sink (input valid, input delta_time, output ready);
endinterface

// envelope result channel
interface lfo_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] envelope_value;
	modport source (output valid, output envelope_value, input ready);
	modport sink (input valid, input envelope_value, output ready);
endinterface

// configuration write channel
interface lfo_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/lfo_waveform_generator.sv */
// path: a tick is held in the stage 1 register, then its envelope in the stage 2 register
// throughput: one item per cycle while env.ready does not stall the output, set by the single phase adder and the
// table lookup plus range multiply between the input and result registers
// reset (arst_n low): phase 0, noise lfsr 1, sine mode, range 0 to 32767,
// cycle rate 4096, offset 0, pipeline empty
`include "lfo_waveform_generator_macros.svh"

module lfo_waveform_generator #(
	parameter int SINE_TABLE_BITS = 8
) (
	input logic clk,
	input logic arst_n,
	lfo_in_if.sink tick,
	lfo_out_if.source env,
	lfo_cfg_if.sink cfg
);
	import lfo_pkg::*;

	localparam int FULL = 1 << SINE_TABLE_BITS;
	localparam logic [SINE_TABLE_BITS:0] FULL_K = (SINE_TABLE_BITS + 1)'(FULL);

	// configuration registers
	logic [2:0]  wave_mode_q;
	logic [15:0] range_low_q;
	logic [15:0] range_high_q;
	logic [31:0] cycle_rate_q;
	logic [31:0] phase_offset_q;

	// state
	logic [31:0] phase_q;
	logic [31:0] lfsr_q;

	// pipeline
	logic        v_s1;
	logic [31:0] p_s1;
	logic [31:0] delta_s1;
	logic        v_s2;
	logic [15:0] env_s2;

	// handshake
	logic adv;
	logic fire_s1;
	logic accept;

	// datapath
	logic [39:0]                rate_prod;
	logic [31:0]                phase_next;
	logic [31:0]                lfsr_next;
	logic [15:0]                sine_lut [0:FULL];
	logic [1:0]                 quad;
	logic [SINE_TABLE_BITS-1:0] k_raw;
	logic [SINE_TABLE_BITS:0]   k;
	logic [15:0]                sine_mag;
	logic [31:0]                tri_d;
	logic [16:0]                u;
	logic signed [16:0]         diff;
	logic signed [34:0]         scaled;
	logic [15:0]                res;

	// constant quarter-wave table
	for (genvar gi = 0; gi <= FULL; gi++) begin : g_lut
		assign sine_lut[gi] = quarter_sine(gi, SINE_TABLE_BITS);
	end

	// flow control
	assign adv        = !v_s2 || env.ready;
	assign fire_s1    = v_s1 && adv;
	assign tick.ready = !v_s1 || adv;
	assign accept     = tick.valid && tick.ready;
	assign cfg.ready  = 1'b1;

	// phase advance of the item leaving stage 1, forwarded to the next item
	assign rate_prod  = 40'(delta_s1) * 40'(cycle_rate_q);
	assign phase_next = phase_q + (fire_s1 ? rate_prod[39:8] : 32'd0);

	// lfsr step
	assign lfsr_next = lfsr_q[0] ? ((lfsr_q >> 1) ^ LFSR_MASK) : (lfsr_q >> 1);

	// sine quadrant folding
	assign quad     = p_s1[31:30];
	assign k_raw    = p_s1[29 -: SINE_TABLE_BITS];
	assign k        = quad[0] ? (FULL_K - {1'b0, k_raw}) : {1'b0, k_raw};
	assign sine_mag = sine_lut[k];
	assign tri_d    = p_s1[31] ? (32'd0 - p_s1) : p_s1;

	// wave value offset by one, 0 .. 2.0 in Q2.15
	always_comb begin
		case (wave_mode_q)
			WAVE_SINE: begin
				u = quad[1] ? (U_MID - {1'b0, sine_mag}) : (U_MID + {1'b0, sine_mag});
			end
			WAVE_SQUARE: begin
				u = p_s1[31] ? U_ZERO : U_FULL;
			end
			WAVE_TRIANGLE: begin
				u = tri_d[31:15];
			end
			WAVE_SAW: begin
				u = {1'b0, ~p_s1[31], p_s1[30:16]};
			end
			WAVE_NOISE: begin
				u = {1'b0, lfsr_next[31:16]};
			end
			default: begin
				u = U_MID;
			end
		endcase
	end

	// map onto the configured range, floor of the scaled product
	assign diff   = {range_high_q[15], range_high_q} - {range_low_q[15], range_low_q};
	assign scaled = $signed({1'b0, u}) * diff;
	assign res    = range_low_q + scaled[31:16];

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_mode_q    <= WAVE_SINE;
			range_low_q    <= '0;
			range_high_q   <= RANGE_HIGH_RST;
			cycle_rate_q   <= CYCLE_RATE_RST;
			phase_offset_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_WAVE_MODE:    wave_mode_q    <= cfg.data[2:0];
				REG_RANGE_LOW:    range_low_q    <= cfg.data[15:0];
				REG_RANGE_HIGH:   range_high_q   <= cfg.data[15:0];
				REG_CYCLE_RATE:   cycle_rate_q   <= cfg.data;
				REG_PHASE_OFFSET: phase_offset_q <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	// phase and noise state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			lfsr_q  <= LFSR_SEED;
		end else begin
			phase_q <= phase_next;
			if (fire_s1 && wave_mode_q == WAVE_NOISE) begin
				lfsr_q <= lfsr_next;
			end
		end
	end

	// pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (tick.ready) begin
				v_s1 <= tick.valid;
			end
			if (adv) begin
				v_s2 <= v_s1;
			end
		end
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		if (accept) begin
			p_s1     <= phase_next + phase_offset_q;
			delta_s1 <= tick.delta_time;
		end
		if (fire_s1) begin
			env_s2 <= res;
		end
	end

	assign env.valid          = v_s2;
	assign env.envelope_value = env_s2;

	// phase moves only when an item leaves stage 1
	`LFO_ASSERT_NEXT(a_phase_hold, !fire_s1, phase_q == $past(phase_q))
	// noise state moves only for a noise item leaving stage 1
	`LFO_ASSERT_NEXT(a_lfsr_hold, !(fire_s1 && wave_mode_q == WAVE_NOISE), lfsr_q == $past(lfsr_q))
	// the lfsr never locks up at zero
	`LFO_ASSERT_SAME(a_lfsr_nonzero, 1'b1, lfsr_q != 32'd0)
	// a stalled stage 1 keeps its item
	`LFO_ASSERT_NEXT(a_s1_hold, v_s1 && !adv, v_s1 && p_s1 == $past(p_s1))

endmodule
